@@ rtl/mnrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// mnrgb_pkg
// Shared widths, codes and reset values of the MIDI note to RGB level block.
// ----------------------------------------------------------------------------
package mnrgb_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEVEL_W    = 8;
   localparam int NOTE_W     = 7;
   localparam int CHAN_W     = 4;
   localparam int COUNT_W    = 16;
   localparam int PHASE_W    = 2;
   localparam int COLOUR_W   = 2;
   localparam int NUM_COLOURS = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // input item kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // MIDI status high nibbles
   localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

   localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd0;
   localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd1;
   localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 2'd2;
   localparam logic [COLOUR_W-1:0] NO_COLOUR    = 2'd3;

   // register reset values
   localparam logic [CHAN_W-1:0]  RST_MIDI_CHANNEL    = 4'd0;
   localparam logic [NOTE_W-1:0]  RST_RED_NOTE        = 7'h24;
   localparam logic [NOTE_W-1:0]  RST_GREEN_NOTE      = 7'h28;
   localparam logic [NOTE_W-1:0]  RST_BLUE_NOTE       = 7'h2C;
   localparam logic [COUNT_W-1:0] RST_RELEASE_DELAY   = 16'd100;
   localparam logic [COUNT_W-1:0] RST_MESSAGE_TIMEOUT = 16'd50000;

   typedef enum logic [2:0] {
      CSR_MIDI_CHANNEL    = 3'd0,
      CSR_RED_NOTE        = 3'd1,
      CSR_GREEN_NOTE      = 3'd2,
      CSR_BLUE_NOTE       = 3'd3,
      CSR_RELEASE_DELAY   = 3'd4,
      CSR_MESSAGE_TIMEOUT = 3'd5
   } csr_index_type;

endpackage

@@ rtl/mnrgb_req_if.sv @@
// ----------------------------------------------------------------------------
// mnrgb_req_if
// Input channel: one MIDI byte or one tick per transfer.
// ----------------------------------------------------------------------------
interface mnrgb_req_if;

   logic                            valid;
   logic                            ready;
   logic                            op;
   logic [mnrgb_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);

endinterface

@@ rtl/mnrgb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mnrgb_rsp_if
// Result channel: colour levels, refresh flag and parser phase per transfer.
// ----------------------------------------------------------------------------
interface mnrgb_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [mnrgb_pkg::LEVEL_W-1:0]   red_level;
   logic [mnrgb_pkg::LEVEL_W-1:0]   green_level;
   logic [mnrgb_pkg::LEVEL_W-1:0]   blue_level;
   logic                            refresh;
   logic [mnrgb_pkg::PHASE_W-1:0]   parse_phase;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, output refresh, output parse_phase,
                   input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, input refresh, input parse_phase,
                   output ready);

endinterface

@@ rtl/midi_note_to_rgb_level.sv @@
// ----------------------------------------------------------------------------
// midi_note_to_rgb_level
// MIDI note-message parser driving three colour levels with release timers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries either a received MIDI byte (op = 0) or one time tick
//   (op = 1). Every transfer on req gives exactly one transfer on rsp with
//   the three colour levels after that item, a refresh flag and the parser
//   phase.
//   An item taken on req is offered on rsp in the cycle after. Throughput
//   is one item per cycle while rsp is not stalled; the parser, stall counter
//   and the three release counters all update in the single pass between
//   the state registers and the rsp register.
//   If rsp is stalled, one result is held in the rsp register and req.ready
//   drops until it is taken; nothing is lost or repeated.
//   Reset (synchronous, active high) empties rsp, returns the parser to
//   waiting, clears levels and timers and loads the register defaults.
//   The csr port (APB style, pready always high) holds the MIDI channel,
//   the red/green/blue note numbers, the release delay and the message
//   timeout at byte addresses 0, 4, 8, 12, 16 and 20. Write it only while
//   the block is idle.
// ----------------------------------------------------------------------------
module midi_note_to_rgb_level (
   input  logic                                  clock,
   input  logic                                  reset,
   mnrgb_req_if.sink                             req,
   mnrgb_rsp_if.source                           rsp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mnrgb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mnrgb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mnrgb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   typedef enum logic [mnrgb_pkg::PHASE_W-1:0] {
      PHASE_WAIT   = 2'd0,
      PHASE_STATUS = 2'd1,
      PHASE_NOTE   = 2'd2
   } phase_type;

   // configuration registers
   logic [mnrgb_pkg::CHAN_W-1:0]   midi_channel_ff;
   logic [mnrgb_pkg::NOTE_W-1:0]   red_note_ff;
   logic [mnrgb_pkg::NOTE_W-1:0]   green_note_ff;
   logic [mnrgb_pkg::NOTE_W-1:0]   blue_note_ff;
   logic [mnrgb_pkg::COUNT_W-1:0]  release_delay_ff;
   logic [mnrgb_pkg::COUNT_W-1:0]  message_timeout_ff;

   mnrgb_pkg::csr_index_type       csr_index;
   logic                           csr_write;

   // parser and timer state
   phase_type                      phase_ff, phase_in;
   logic                           note_on_ff, note_on_in;
   logic [mnrgb_pkg::COLOUR_W-1:0] sel_ff, sel_in;
   logic [mnrgb_pkg::COUNT_W-1:0]  stall_ff, stall_in;
   logic [mnrgb_pkg::LEVEL_W-1:0]  levels_ff [mnrgb_pkg::NUM_COLOURS];
   logic [mnrgb_pkg::LEVEL_W-1:0]  levels_in [mnrgb_pkg::NUM_COLOURS];
   logic                           armed_ff  [mnrgb_pkg::NUM_COLOURS];
   logic                           armed_in  [mnrgb_pkg::NUM_COLOURS];
   logic [mnrgb_pkg::COUNT_W-1:0]  count_ff  [mnrgb_pkg::NUM_COLOURS];
   logic [mnrgb_pkg::COUNT_W-1:0]  count_in  [mnrgb_pkg::NUM_COLOURS];
   logic                           refresh_in;

   // result register
   logic                           rsp_valid_ff;
   logic [mnrgb_pkg::LEVEL_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                           rsp_refresh_ff;
   logic [mnrgb_pkg::PHASE_W-1:0]  rsp_phase_ff;

   logic                           accept;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = mnrgb_pkg::csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         mnrgb_pkg::CSR_MIDI_CHANNEL:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(midi_channel_ff);
         mnrgb_pkg::CSR_RED_NOTE:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(red_note_ff);
         mnrgb_pkg::CSR_GREEN_NOTE:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(green_note_ff);
         mnrgb_pkg::CSR_BLUE_NOTE:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(blue_note_ff);
         mnrgb_pkg::CSR_RELEASE_DELAY:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(release_delay_ff);
         mnrgb_pkg::CSR_MESSAGE_TIMEOUT:
            csr_prdata = mnrgb_pkg::CSR_DATA_W'(message_timeout_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         midi_channel_ff    <= mnrgb_pkg::RST_MIDI_CHANNEL;
         red_note_ff        <= mnrgb_pkg::RST_RED_NOTE;
         green_note_ff      <= mnrgb_pkg::RST_GREEN_NOTE;
         blue_note_ff       <= mnrgb_pkg::RST_BLUE_NOTE;
         release_delay_ff   <= mnrgb_pkg::RST_RELEASE_DELAY;
         message_timeout_ff <= mnrgb_pkg::RST_MESSAGE_TIMEOUT;
      end else if (csr_write) begin
         case (csr_index)
            mnrgb_pkg::CSR_MIDI_CHANNEL:
               midi_channel_ff <= csr_pwdata[mnrgb_pkg::CHAN_W-1:0];
            mnrgb_pkg::CSR_RED_NOTE:
               red_note_ff <= csr_pwdata[mnrgb_pkg::NOTE_W-1:0];
            mnrgb_pkg::CSR_GREEN_NOTE:
               green_note_ff <= csr_pwdata[mnrgb_pkg::NOTE_W-1:0];
            mnrgb_pkg::CSR_BLUE_NOTE:
               blue_note_ff <= csr_pwdata[mnrgb_pkg::NOTE_W-1:0];
            mnrgb_pkg::CSR_RELEASE_DELAY:
               release_delay_ff <= csr_pwdata[mnrgb_pkg::COUNT_W-1:0];
            mnrgb_pkg::CSR_MESSAGE_TIMEOUT:
               message_timeout_ff <= csr_pwdata[mnrgb_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- handshake
   // rsp register frees up in the same cycle it is taken
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // -------------------------------------------------------- next state
   always_comb begin
      logic [3:0]                    hi;
      logic [3:0]                    lo;
      logic [mnrgb_pkg::COLOUR_W-1:0] found;
      logic [mnrgb_pkg::COUNT_W-1:0]  stall_inc;

      hi         = req.rx_byte[7:4];
      lo         = req.rx_byte[3:0];
      found      = mnrgb_pkg::NO_COLOUR;
      stall_inc  = stall_ff + 16'd1;

      phase_in   = phase_ff;
      note_on_in = note_on_ff;
      sel_in     = sel_ff;
      stall_in   = stall_ff;
      levels_in  = levels_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      refresh_in = 1'b0;

      if (req.op == mnrgb_pkg::OP_BYTE) begin
         case (phase_ff)
            PHASE_WAIT: begin
               if ((hi == mnrgb_pkg::STATUS_NOTE_OFF || hi == mnrgb_pkg::STATUS_NOTE_ON)
                   && lo == midi_channel_ff) begin
                  phase_in   = PHASE_STATUS;
                  note_on_in = (hi == mnrgb_pkg::STATUS_NOTE_ON);
                  stall_in   = '0;
               end
            end
            PHASE_STATUS: begin
               // red beats green beats blue on equal note numbers
               if (!req.rx_byte[7]) begin
                  if (req.rx_byte[6:0] == red_note_ff)
                     found = mnrgb_pkg::COLOUR_RED;
                  else if (req.rx_byte[6:0] == green_note_ff)
                     found = mnrgb_pkg::COLOUR_GREEN;
                  else if (req.rx_byte[6:0] == blue_note_ff)
                     found = mnrgb_pkg::COLOUR_BLUE;
               end
               sel_in   = found;
               stall_in = '0;
               if (found != mnrgb_pkg::NO_COLOUR)
                  phase_in = PHASE_NOTE;
               else
                  phase_in = PHASE_WAIT;
            end
            PHASE_NOTE: begin
               if (!req.rx_byte[7] && sel_ff != mnrgb_pkg::NO_COLOUR) begin
                  if (note_on_ff) begin
                     levels_in[sel_ff] = {req.rx_byte[6:0], 1'b0};
                     armed_in[sel_ff]  = 1'b0;
                  end else begin
                     armed_in[sel_ff]  = 1'b1;
                     count_in[sel_ff]  = release_delay_ff;
                  end
                  refresh_in = 1'b1;
               end
               phase_in = PHASE_WAIT;
               sel_in   = mnrgb_pkg::NO_COLOUR;
               stall_in = '0;
            end
            default: begin
               phase_in = PHASE_WAIT;
               sel_in   = mnrgb_pkg::NO_COLOUR;
               stall_in = '0;
            end
         endcase
      end else begin
         if (phase_ff == PHASE_STATUS || phase_ff == PHASE_NOTE) begin
            stall_in = stall_inc;
            if (stall_inc == message_timeout_ff) begin
               phase_in = PHASE_WAIT;
               sel_in   = mnrgb_pkg::NO_COLOUR;
               stall_in = '0;
            end
         end
         for (int c = 0; c < mnrgb_pkg::NUM_COLOURS; c++) begin
            if (count_ff[c] != '0) begin
               count_in[c] = count_ff[c] - 16'd1;
               if (count_ff[c] == 16'd1 && armed_ff[c]) begin
                  levels_in[c] = '0;
                  armed_in[c]  = 1'b0;
                  refresh_in   = 1'b1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_WAIT;
         note_on_ff   <= 1'b1;
         sel_ff       <= mnrgb_pkg::NO_COLOUR;
         stall_ff     <= '0;
         for (int c = 0; c < mnrgb_pkg::NUM_COLOURS; c++) begin
            levels_ff[c] <= '0;
            armed_ff[c]  <= 1'b0;
            count_ff[c]  <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            note_on_ff   <= note_on_in;
            sel_ff       <= sel_in;
            stall_ff     <= stall_in;
            levels_ff    <= levels_in;
            armed_ff     <= armed_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_red_ff     <= levels_in[mnrgb_pkg::COLOUR_RED];
         rsp_green_ff   <= levels_in[mnrgb_pkg::COLOUR_GREEN];
         rsp_blue_ff    <= levels_in[mnrgb_pkg::COLOUR_BLUE];
         rsp_refresh_ff <= refresh_in;
         rsp_phase_ff   <= phase_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.red_level   = rsp_red_ff;
   assign rsp.green_level = rsp_green_ff;
   assign rsp.blue_level  = rsp_blue_ff;
   assign rsp.refresh     = rsp_refresh_ff;
   assign rsp.parse_phase = rsp_phase_ff;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks midi_note_to_rgb_level: a directed table of MIDI bytes and ticks,
// then random note messages, noise and ticks under six register settings.
// Each result is compared field by field with a directed row's typed value
// or a local tracker of the parser, colour levels and release timers. Both
// channels idle at random, and the result side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mnrgb_pkg::PHASE_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [mnrgb_pkg::PHASE_W-1:0] PH_STATUS = 2'd1;
   localparam logic [mnrgb_pkg::PHASE_W-1:0] PH_NOTE   = 2'd2;

   localparam int LIMIT_CYCLES    = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 400;
   localparam int RANDOM_PER_SET  = 115;
   localparam int NUM_SETTINGS    = 6;
   localparam int NUM_DIRECTED    = 26;

   typedef struct packed {
      logic [mnrgb_pkg::LEVEL_W-1:0] red;
      logic [mnrgb_pkg::LEVEL_W-1:0] green;
      logic [mnrgb_pkg::LEVEL_W-1:0] blue;
      logic                          refresh;
      logic [mnrgb_pkg::PHASE_W-1:0] phase;
   } levels_type;

   typedef struct packed {
      logic                         op;
      logic [mnrgb_pkg::BYTE_W-1:0] rx_byte;
      logic                         typed;
      levels_type                   want;
   } midi_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [mnrgb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mnrgb_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mnrgb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   mnrgb_req_if req_if ();
   mnrgb_rsp_if rsp_if ();

   midi_note_to_rgb_level i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // register shadow
   logic [mnrgb_pkg::CHAN_W-1:0]  cfg_channel;
   logic [mnrgb_pkg::NOTE_W-1:0]  cfg_red_note;
   logic [mnrgb_pkg::NOTE_W-1:0]  cfg_green_note;
   logic [mnrgb_pkg::NOTE_W-1:0]  cfg_blue_note;
   logic [mnrgb_pkg::COUNT_W-1:0] cfg_release;
   logic [mnrgb_pkg::COUNT_W-1:0] cfg_timeout;

   // tracked parser and colour state
   logic [mnrgb_pkg::PHASE_W-1:0]  trk_phase;
   logic                           trk_note_on;
   logic [mnrgb_pkg::COLOUR_W-1:0] trk_colour;
   logic [mnrgb_pkg::COUNT_W-1:0]  trk_stall;
   logic [mnrgb_pkg::LEVEL_W-1:0]  trk_level   [mnrgb_pkg::NUM_COLOURS];
   logic                           trk_armed   [mnrgb_pkg::NUM_COLOURS];
   logic [mnrgb_pkg::COUNT_W-1:0]  trk_release [mnrgb_pkg::NUM_COLOURS];

   levels_type   expected_levels [$];
   midi_row_type directed_rows [NUM_DIRECTED];

   logic       cur_typed;
   levels_type cur_want;
   bit         quiet;
   bit         hold_off_done;
   int         cycle_count;
   int         accepted_count;
   int         tick_count;
   int         checked_count;
   int         fail_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_levels.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void back_to_idle();
      trk_phase  = PH_IDLE;
      trk_colour = mnrgb_pkg::NO_COLOUR;
      trk_stall  = '0;
   endfunction

   // one MIDI byte or tick through the tracker; returns the result it gives
   function automatic levels_type predict_levels(logic op,
                                                 logic [mnrgb_pkg::BYTE_W-1:0] b);
      logic                           fresh;
      logic [mnrgb_pkg::COLOUR_W-1:0] sel;
      levels_type                     r;
      fresh = 1'b0;
      if (op == mnrgb_pkg::OP_BYTE) begin
         case (trk_phase)
            PH_IDLE: begin
               if ((b[7:4] == mnrgb_pkg::STATUS_NOTE_OFF ||
                    b[7:4] == mnrgb_pkg::STATUS_NOTE_ON) &&
                   b[3:0] == cfg_channel) begin
                  trk_phase   = PH_STATUS;
                  trk_note_on = (b[7:4] == mnrgb_pkg::STATUS_NOTE_ON);
                  trk_stall   = '0;
               end
            end
            PH_STATUS: begin
               sel = mnrgb_pkg::NO_COLOUR;
               if (!b[7]) begin
                  if (b[6:0] == cfg_red_note)        sel = mnrgb_pkg::COLOUR_RED;
                  else if (b[6:0] == cfg_green_note) sel = mnrgb_pkg::COLOUR_GREEN;
                  else if (b[6:0] == cfg_blue_note)  sel = mnrgb_pkg::COLOUR_BLUE;
               end
               if (sel != mnrgb_pkg::NO_COLOUR) begin
                  trk_colour = sel;
                  trk_phase  = PH_NOTE;
                  trk_stall  = '0;
               end else begin
                  back_to_idle();
               end
            end
            PH_NOTE: begin
               if (!b[7] && trk_colour != mnrgb_pkg::NO_COLOUR) begin
                  if (trk_note_on) begin
                     trk_level[trk_colour] = {b[6:0], 1'b0};
                     trk_armed[trk_colour] = 1'b0;
                  end else begin
                     trk_armed[trk_colour]   = 1'b1;
                     trk_release[trk_colour] = cfg_release;
                  end
                  fresh = 1'b1;
               end
               back_to_idle();
            end
            default: back_to_idle();
         endcase
      end else begin
         if (trk_phase == PH_STATUS || trk_phase == PH_NOTE) begin
            trk_stall = trk_stall + 16'd1;
            if (trk_stall == cfg_timeout) back_to_idle();
         end
         for (int c = 0; c < mnrgb_pkg::NUM_COLOURS; c++) begin
            if (trk_release[c] != '0) begin
               trk_release[c] = trk_release[c] - 16'd1;
               if (trk_release[c] == '0 && trk_armed[c]) begin
                  trk_level[c] = '0;
                  trk_armed[c] = 1'b0;
                  fresh        = 1'b1;
               end
            end
         end
      end
      r = '{trk_level[0], trk_level[1], trk_level[2], fresh, trk_phase};
      return r;
   endfunction

   // transfer monitor: check outgoing results, then record incoming items
   always @(posedge clock) begin
      levels_type got;
      levels_type want;
      levels_type pred;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.red_level, rsp_if.green_level, rsp_if.blue_level,
                    rsp_if.refresh, rsp_if.parse_phase};
            if (expected_levels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"Result with nothing outstanding: ",
                            "r=%0d g=%0d b=%0d rf=%0b ph=%0d"},
                           got.red, got.green, got.blue, got.refresh, got.phase);
            end else begin
               want = expected_levels.pop_front();
               checked_count++;
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.refresh !== want.refresh ||
                   got.phase !== want.phase) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"Mismatch on result %0d: ",
                               "exp r=%0d g=%0d b=%0d rf=%0b ph=%0d, ",
                               "got r=%0d g=%0d b=%0d rf=%0b ph=%0d"},
                              checked_count, want.red, want.green, want.blue,
                              want.refresh, want.phase, got.red, got.green,
                              got.blue, got.refresh, got.phase);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            pred = predict_levels(req_if.op, req_if.rx_byte);
            expected_levels.push_back(cur_typed ? cur_want : pred);
            accepted_count++;
            if (req_if.op == mnrgb_pkg::OP_TICK) tick_count++;
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random back-pressure, plus one long hold-off
   initial begin
      int g;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_off_done && accepted_count >= HOLD_OFF_AT) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_done = 1'b1;
         end else begin
            g = idle_gap();
            if (g == 0) begin
               rsp_if.ready = 1'b1;
            end else begin
               rsp_if.ready = 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic send_item(logic op, logic [mnrgb_pkg::BYTE_W-1:0] b, logic typed,
                            levels_type want);
      int g;
      g = idle_gap();
      repeat (g) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.op      = op;
      req_if.rx_byte = b;
      cur_typed      = typed;
      cur_want       = want;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(mnrgb_pkg::csr_index_type idx,
                            logic [mnrgb_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = mnrgb_pkg::CSR_ADDR_W'(idx) << 2;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         mnrgb_pkg::CSR_MIDI_CHANNEL:
            cfg_channel    = value[mnrgb_pkg::CHAN_W-1:0];
         mnrgb_pkg::CSR_RED_NOTE:
            cfg_red_note   = value[mnrgb_pkg::NOTE_W-1:0];
         mnrgb_pkg::CSR_GREEN_NOTE:
            cfg_green_note = value[mnrgb_pkg::NOTE_W-1:0];
         mnrgb_pkg::CSR_BLUE_NOTE:
            cfg_blue_note  = value[mnrgb_pkg::NOTE_W-1:0];
         mnrgb_pkg::CSR_RELEASE_DELAY:
            cfg_release    = value[mnrgb_pkg::COUNT_W-1:0];
         mnrgb_pkg::CSR_MESSAGE_TIMEOUT:
            cfg_timeout    = value[mnrgb_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_setting(int chan, int red, int green, int blue,
                                int rel, int tmo);
      csr_write(mnrgb_pkg::CSR_MIDI_CHANNEL, chan);
      csr_write(mnrgb_pkg::CSR_RED_NOTE, red);
      csr_write(mnrgb_pkg::CSR_GREEN_NOTE, green);
      csr_write(mnrgb_pkg::CSR_BLUE_NOTE, blue);
      csr_write(mnrgb_pkg::CSR_RELEASE_DELAY, rel);
      csr_write(mnrgb_pkg::CSR_MESSAGE_TIMEOUT, tmo);
   endtask

   // mostly complete note messages with random content, plus noise and ticks
   task automatic run_random(int n);
      int                           k;
      int                           r;
      logic [mnrgb_pkg::BYTE_W-1:0] st;
      logic [mnrgb_pkg::BYTE_W-1:0] nt;
      logic [mnrgb_pkg::BYTE_W-1:0] vel;
      k = 0;
      while (k < n) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            send_item(mnrgb_pkg::OP_TICK, 8'($urandom), 1'b0, '0);
            k++;
         end else if (r < 40) begin
            send_item(mnrgb_pkg::OP_BYTE, 8'($urandom), 1'b0, '0);
            k++;
         end else begin
            if ($urandom_range(0, 99) < 85)
               st = {($urandom_range(0, 1) ? mnrgb_pkg::STATUS_NOTE_ON
                                           : mnrgb_pkg::STATUS_NOTE_OFF), cfg_channel};
            else
               st = {($urandom_range(0, 1) ? mnrgb_pkg::STATUS_NOTE_ON
                                           : mnrgb_pkg::STATUS_NOTE_OFF),
                     4'($urandom_range(0, 15))};
            case ($urandom_range(0, 9))
               0, 1, 2: nt = {1'b0, cfg_red_note};
               3, 4:    nt = {1'b0, cfg_green_note};
               5, 6, 7: nt = {1'b0, cfg_blue_note};
               8:       nt = {1'b0, 7'($urandom)};
               default: nt = 8'($urandom);
            endcase
            vel = ($urandom_range(0, 9) == 0) ? 8'h80 | 8'($urandom)
                                              : {1'b0, 7'($urandom)};
            send_item(mnrgb_pkg::OP_BYTE, st, 1'b0, '0);
            if ($urandom_range(0, 99) < 15)
               repeat ($urandom_range(1, 4))
                  send_item(mnrgb_pkg::OP_TICK, 8'($urandom), 1'b0, '0);
            send_item(mnrgb_pkg::OP_BYTE, nt, 1'b0, '0);
            if ($urandom_range(0, 99) < 15)
               repeat ($urandom_range(1, 4))
                  send_item(mnrgb_pkg::OP_TICK, 8'($urandom), 1'b0, '0);
            send_item(mnrgb_pkg::OP_BYTE, vel, 1'b0, '0);
            k += 3;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.op     = mnrgb_pkg::OP_BYTE;
      req_if.rx_byte = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      cur_typed     = 1'b0;
      cur_want      = '0;
      quiet         = 1'b0;
      hold_off_done = 1'b0;
      cycle_count   = 0;
      accepted_count = 0;
      tick_count    = 0;
      checked_count = 0;
      fail_count    = 0;

      cfg_channel    = mnrgb_pkg::RST_MIDI_CHANNEL;
      cfg_red_note   = mnrgb_pkg::RST_RED_NOTE;
      cfg_green_note = mnrgb_pkg::RST_GREEN_NOTE;
      cfg_blue_note  = mnrgb_pkg::RST_BLUE_NOTE;
      cfg_release    = mnrgb_pkg::RST_RELEASE_DELAY;
      cfg_timeout    = mnrgb_pkg::RST_MESSAGE_TIMEOUT;
      trk_phase      = PH_IDLE;
      trk_note_on    = 1'b1;
      trk_colour     = mnrgb_pkg::NO_COLOUR;
      trk_stall      = '0;
      for (int c = 0; c < mnrgb_pkg::NUM_COLOURS; c++) begin
         trk_level[c]   = '0;
         trk_armed[c]   = 1'b0;
         trk_release[c] = '0;
      end

      directed_rows = '{
         '{mnrgb_pkg::OP_TICK, 8'h00, 1'b1,
           '{8'd0, 8'd0, 8'd0, 1'b0, PH_IDLE}},                    // tick after reset
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b1,
           '{8'd0, 8'd0, 8'd0, 1'b0, PH_STATUS}},
         '{mnrgb_pkg::OP_BYTE, 8'h24, 1'b1,
           '{8'd0, 8'd0, 8'd0, 1'b0, PH_NOTE}},
         '{mnrgb_pkg::OP_BYTE, 8'h7F, 1'b1,
           '{8'd254, 8'd0, 8'd0, 1'b1, PH_IDLE}},                  // top velocity
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h28, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h00, 1'b0, '0},                   // zero velocity
         '{mnrgb_pkg::OP_BYTE, 8'h91, 1'b1,
           '{8'd254, 8'd0, 8'd0, 1'b0, PH_IDLE}},                  // other channel
         '{mnrgb_pkg::OP_BYTE, 8'h80, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h2C, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h40, 1'b0, '0},                   // note-off on blue
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b1,
           '{8'd254, 8'd0, 8'd0, 1'b0, PH_IDLE}},                  // status as note
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h24, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'hFF, 1'b1,
           '{8'd254, 8'd0, 8'd0, 1'b0, PH_IDLE}},                  // status as velocity
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h7F, 1'b0, '0},                   // unmatched note
         '{mnrgb_pkg::OP_BYTE, 8'hF0, 1'b0, '0},                   // system byte, waiting
         '{mnrgb_pkg::OP_BYTE, 8'h00, 1'b0, '0},                   // stray data byte
         '{mnrgb_pkg::OP_BYTE, 8'h80, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h24, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h01, 1'b0, '0},                   // arms red release
         '{mnrgb_pkg::OP_BYTE, 8'h90, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h24, 1'b0, '0},
         '{mnrgb_pkg::OP_BYTE, 8'h10, 1'b0, '0}                    // note-on while armed
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].rx_byte,
                   directed_rows[i].typed, directed_rows[i].want);
      drain();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         case (s)
            0: write_setting(15, 0, 127, 64, 1, 1);
            1: write_setting(5, 60, 60, 60, 65535, 65535);     // equal notes
            2: write_setting(9, 1, 2, 3, 3, 4);
            3: write_setting($urandom_range(0, 15), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127), 0, 0);
            4: write_setting($urandom_range(0, 15), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(1, 20), $urandom_range(2, 10));
            default: write_setting(0, $urandom_range(0, 127), $urandom_range(0, 127),
                                   $urandom_range(0, 127), $urandom_range(1, 40),
                                   $urandom_range(3, 30));
         endcase
         quiet = (s == 2);
         run_random(RANDOM_PER_SET);
         drain();
      end
      quiet = 1'b0;
      repeat (5) @(posedge clock);

      $display("Covered %0d transfers (%0d ticks) over the reset and %0d other settings",
               accepted_count, tick_count, NUM_SETTINGS);
      $display("%0d results compared, %0d mismatches, one %0d-cycle result hold-off",
               checked_count, fail_count, HOLD_OFF_CYCLES);
      if (fail_count == 0 && expected_levels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
